### hw/rtl/bts_pkg.sv
// shared types, constants and register indexes of the ball tracking stage block
package bts_pkg;

   localparam int TIMER_BITS = 16;
   localparam int MS_BITS    = 16;
   localparam int SUM_BITS   = ((TIMER_BITS > MS_BITS) ? TIMER_BITS : MS_BITS) + 1;
   localparam int DIST_BITS  = 12;
   localparam int TOL_BITS   = 13;
   localparam int ANG_BITS   = 16;
   localparam int HERR_BITS  = 15;
   localparam int WRAP_BITS  = 18;
   localparam int IDX_BITS   = 3;
   localparam int CSR_BITS   = 16;
   localparam int REQ_BYTES  = 8;
   localparam int RSP_BYTES  = 5;

   localparam logic signed [WRAP_BITS-1:0] FULL_TURN     = 18'sd36000;
   localparam logic signed [WRAP_BITS-1:0] HALF_TURN     = 18'sd18000;
   localparam logic signed [WRAP_BITS-1:0] NEG_FULL_TURN = -18'sd36000;
   localparam logic signed [WRAP_BITS-1:0] TWO_TURNS     = 18'sd72000;

   localparam logic [IDX_BITS-1:0] CSR_ORBIT_DISTANCE  = 3'd0;
   localparam logic [IDX_BITS-1:0] CSR_ORBIT_ENTRY_TOL = 3'd1;
   localparam logic [IDX_BITS-1:0] CSR_ORBIT_EXIT_TOL  = 3'd2;
   localparam logic [IDX_BITS-1:0] CSR_ORBIT_DEBOUNCE  = 3'd3;
   localparam logic [IDX_BITS-1:0] CSR_ENTER_ALIGN_TOL = 3'd4;
   localparam logic [IDX_BITS-1:0] CSR_EXIT_ALIGN_TOL  = 3'd5;
   localparam logic [IDX_BITS-1:0] CSR_ALIGN_DEBOUNCE  = 3'd6;

   localparam logic [1:0] CODE_SEARCH   = 2'd0;
   localparam logic [1:0] CODE_APPROACH = 2'd1;
   localparam logic [1:0] CODE_ORBIT    = 2'd2;
   localparam logic [1:0] CODE_CAPTURED = 2'd3;

   typedef enum logic [3:0] {
      ST_SEARCH   = 4'b0001,
      ST_APPROACH = 4'b0010,
      ST_ORBIT    = 4'b0100,
      ST_CAPTURED = 4'b1000
   } stage_type;

   typedef logic [TIMER_BITS-1:0] timer_type;

   typedef struct packed {
      logic                        ball_found;
      logic [DIST_BITS-1:0]        signal_strength;
      logic signed [ANG_BITS-1:0]  ball_direction;
      logic signed [ANG_BITS-1:0]  target_heading;
      logic [MS_BITS-1:0]          elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [DIST_BITS-1:0]        target_strength;
      logic signed [TOL_BITS-1:0]  entry_tol;
      logic signed [TOL_BITS-1:0]  exit_tol;
      logic [MS_BITS-1:0]          orbit_hold_ms;
      logic [HERR_BITS-1:0]        enter_align_tolerance;
      logic [HERR_BITS-1:0]        exit_align_tolerance;
      logic [MS_BITS-1:0]          align_hold_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         stage;
      logic [MS_BITS-1:0] aligned_ms;
      logic [MS_BITS-1:0] orbit_ms;
   } rsp_type;

endpackage

### hw/rtl/bts_heading_err.sv
// wrapped absolute heading error in centidegrees
module bts_heading_err (
   input  logic signed [bts_pkg::ANG_BITS-1:0] ball_direction,
   input  logic signed [bts_pkg::ANG_BITS-1:0] target_heading,
   output logic [bts_pkg::HERR_BITS-1:0]       heading_err
);

   logic signed [bts_pkg::WRAP_BITS-1:0] diff;
   logic signed [bts_pkg::WRAP_BITS-1:0] wrapped;
   logic signed [bts_pkg::WRAP_BITS-1:0] folded;

   always_comb begin
      diff = bts_pkg::WRAP_BITS'(target_heading) - bts_pkg::WRAP_BITS'(ball_direction);
      priority if (diff >= bts_pkg::FULL_TURN) begin
         wrapped = diff - bts_pkg::FULL_TURN;
      end else if (diff < bts_pkg::NEG_FULL_TURN) begin
         wrapped = diff + bts_pkg::TWO_TURNS;
      end else if (diff < 0) begin
         wrapped = diff + bts_pkg::FULL_TURN;
      end else begin
         wrapped = diff;
      end
      if (wrapped > bts_pkg::HALF_TURN) begin
         folded = bts_pkg::FULL_TURN - wrapped;
      end else begin
         folded = wrapped;
      end
      heading_err = folded[bts_pkg::HERR_BITS-1:0];
   end

endmodule

### hw/rtl/bts_stage_core.sv
// tracking stage register, debounce timers and their next-state logic
module bts_stage_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  bts_pkg::req_type req,
   input  bts_pkg::cfg_type cfg,
   output bts_pkg::rsp_type rsp
);

   bts_pkg::stage_type stage_ff, stage_in;
   bts_pkg::timer_type aligned_ff, aligned_in;
   bts_pkg::timer_type orbit_ff, orbit_in;

   logic [bts_pkg::HERR_BITS-1:0]       heading_err;
   logic signed [bts_pkg::TOL_BITS-1:0] dist_err;
   bts_pkg::timer_type                  orbit_sum;
   bts_pkg::timer_type                  aligned_sum;
   logic                                orbit_done;
   logic                                aligned_done;

   function automatic bts_pkg::timer_type sat_add(bts_pkg::timer_type t,
                                                  logic [bts_pkg::MS_BITS-1:0] d);
      logic [bts_pkg::SUM_BITS-1:0] sum;
      sum = bts_pkg::SUM_BITS'(t) + bts_pkg::SUM_BITS'(d);
      if (sum > bts_pkg::SUM_BITS'({bts_pkg::TIMER_BITS{1'b1}})) begin
         return {bts_pkg::TIMER_BITS{1'b1}};
      end
      return sum[bts_pkg::TIMER_BITS-1:0];
   endfunction

   function automatic logic reached(bts_pkg::timer_type t,
                                    logic [bts_pkg::MS_BITS-1:0] limit);
      return bts_pkg::SUM_BITS'(t) >= bts_pkg::SUM_BITS'(limit);
   endfunction

   function automatic logic [bts_pkg::MS_BITS-1:0] to_ms(bts_pkg::timer_type t);
      logic [bts_pkg::SUM_BITS-1:0] w;
      w = bts_pkg::SUM_BITS'(t);
      return w[bts_pkg::MS_BITS-1:0];
   endfunction

   function automatic logic [1:0] stage_code(bts_pkg::stage_type s);
      logic [1:0] c;
      unique case (s)
         bts_pkg::ST_APPROACH: c = bts_pkg::CODE_APPROACH;
         bts_pkg::ST_ORBIT:    c = bts_pkg::CODE_ORBIT;
         bts_pkg::ST_CAPTURED: c = bts_pkg::CODE_CAPTURED;
         default:              c = bts_pkg::CODE_SEARCH;
      endcase
      return c;
   endfunction

   bts_heading_err u_heading_err (
      .ball_direction (req.ball_direction),
      .target_heading (req.target_heading),
      .heading_err    (heading_err)
   );

   always_comb begin
      dist_err = $signed({1'b0, cfg.target_strength}) - $signed({1'b0, req.signal_strength});
      orbit_sum    = sat_add(orbit_ff, req.elapsed_ms);
      aligned_sum  = sat_add(aligned_ff, req.elapsed_ms);
      orbit_done   = reached(orbit_sum, cfg.orbit_hold_ms);
      aligned_done = reached(aligned_sum, cfg.align_hold_ms);

      stage_in   = stage_ff;
      aligned_in = aligned_ff;
      orbit_in   = orbit_ff;

      if (!req.ball_found) begin
         stage_in   = bts_pkg::ST_SEARCH;
         aligned_in = '0;
         orbit_in   = '0;
      end else begin
         unique case (stage_ff)
            bts_pkg::ST_ORBIT: begin
               if (dist_err > cfg.exit_tol) begin
                  stage_in   = bts_pkg::ST_APPROACH;
                  aligned_in = '0;
               end else if (heading_err > cfg.enter_align_tolerance) begin
                  aligned_in = '0;
               end else begin
                  aligned_in = aligned_sum;
                  if (aligned_done && (req.signal_strength > cfg.target_strength)) begin
                     stage_in = bts_pkg::ST_CAPTURED;
                  end
               end
            end
            bts_pkg::ST_CAPTURED: begin
               if (heading_err > cfg.exit_align_tolerance) begin
                  stage_in   = bts_pkg::ST_ORBIT;
                  aligned_in = '0;
               end
            end
            default: begin
               // search and approach share the orbit entry debounce
               if (dist_err < cfg.entry_tol) begin
                  if (orbit_done) begin
                     stage_in = bts_pkg::ST_ORBIT;
                     orbit_in = '0;
                  end else begin
                     orbit_in = orbit_sum;
                  end
               end else begin
                  orbit_in = '0;
               end
            end
         endcase
      end

      rsp.stage      = stage_code(stage_in);
      rsp.aligned_ms = to_ms(aligned_in);
      rsp.orbit_ms   = to_ms(orbit_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff   <= bts_pkg::ST_SEARCH;
         aligned_ff <= '0;
         orbit_ff   <= '0;
      end else if (step) begin
         stage_ff   <= stage_in;
         aligned_ff <= aligned_in;
         orbit_ff   <= orbit_in;
      end
   end

endmodule

### hw/rtl/ball_tracking_stage_fsm_top.sv
// top level: request register, configuration registers, stage core and response register
//
// One control tick per request: a request is taken every cycle while the response side
// keeps up. Its response passes through the request register, then the response register,
// and is held there until taken. The stage and both debounce timers are updated in the same
// cycle the response register loads, so the next request already sees them. Configuration
// registers reset to zero and are written through csr_we, csr_index and csr_wdata; unused
// indexes are ignored.
module ball_tracking_stage_fsm_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // signal_strength, ball_direction, target_heading, elapsed_ms, zero pad
   input  logic [bts_pkg::REQ_BYTES*8-1:0]       req_tdata,
   // ball_found
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // stage, aligned_ms, orbit_ms, zero pad
   output logic [bts_pkg::RSP_BYTES*8-1:0]       rsp_tdata,
   input  logic                                  csr_we,
   input  logic [bts_pkg::IDX_BITS-1:0]          csr_index,
   input  logic [bts_pkg::CSR_BITS-1:0]          csr_wdata
);

   localparam int RSP_USED = 2 + 2 * bts_pkg::MS_BITS;

   logic             req_valid_ff;
   bts_pkg::req_type req_ff, req_in;
   logic             rsp_valid_ff, rsp_valid_in;
   bts_pkg::rsp_type rsp_ff;
   bts_pkg::rsp_type rsp_next;
   bts_pkg::cfg_type cfg_ff;
   logic             rsp_free;
   logic             step;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign step       = req_valid_ff && rsp_free;
   assign req_tready = !req_valid_ff || rsp_free;

   always_comb begin
      req_in.ball_found      = req_tuser;
      req_in.signal_strength = req_tdata[11:0];
      req_in.ball_direction  = req_tdata[27:12];
      req_in.target_heading  = req_tdata[43:28];
      req_in.elapsed_ms      = req_tdata[59:44];
      rsp_valid_in           = step || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff <= req_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            bts_pkg::CSR_ORBIT_DISTANCE:
               cfg_ff.target_strength <= csr_wdata[bts_pkg::DIST_BITS-1:0];
            bts_pkg::CSR_ORBIT_ENTRY_TOL:
               cfg_ff.entry_tol <= csr_wdata[bts_pkg::TOL_BITS-1:0];
            bts_pkg::CSR_ORBIT_EXIT_TOL:
               cfg_ff.exit_tol <= csr_wdata[bts_pkg::TOL_BITS-1:0];
            bts_pkg::CSR_ORBIT_DEBOUNCE:
               cfg_ff.orbit_hold_ms <= csr_wdata[bts_pkg::MS_BITS-1:0];
            bts_pkg::CSR_ENTER_ALIGN_TOL:
               cfg_ff.enter_align_tolerance <= csr_wdata[bts_pkg::HERR_BITS-1:0];
            bts_pkg::CSR_EXIT_ALIGN_TOL:
               cfg_ff.exit_align_tolerance <= csr_wdata[bts_pkg::HERR_BITS-1:0];
            bts_pkg::CSR_ALIGN_DEBOUNCE:
               cfg_ff.align_hold_ms <= csr_wdata[bts_pkg::MS_BITS-1:0];
            default: ;
         endcase
      end
   end

   bts_stage_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_ff),
      .cfg   (cfg_ff),
      .rsp   (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(bts_pkg::RSP_BYTES*8-RSP_USED){1'b0}},
                        rsp_ff.orbit_ms, rsp_ff.aligned_ms, rsp_ff.stage};

endmodule

### test/tb_top.sv
// ball tracking stage testbench: directed table and random phases, responses checked against table or predictor
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_TICKS = 1350;
   localparam int TIMER_MAX    = (1 << bts_pkg::TIMER_BITS) - 1;
   localparam int NUM_INDEXES  = 1 << bts_pkg::IDX_BITS;

   typedef logic [bts_pkg::CSR_BITS-1:0] reg_set_type [NUM_INDEXES];

   typedef struct {
      int         setting;
      bit         found;
      int         sig;
      int         dir;
      int         tgt;
      int         ms;
      bit         typed;
      logic [1:0] stage;
      int         aligned;
      int         orbit;
   } tick_row_type;

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [bts_pkg::REQ_BYTES*8-1:0]     req_tdata;
   logic                                req_tuser;
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [bts_pkg::RSP_BYTES*8-1:0]     rsp_tdata;
   logic                                csr_we;
   logic [bts_pkg::IDX_BITS-1:0]        csr_index;
   logic [bts_pkg::CSR_BITS-1:0]        csr_wdata;

   // tracker copy: stage, timers and register values
   logic [1:0] track_stage = bts_pkg::CODE_SEARCH;
   int         align_acc = 0;
   int         orbit_acc = 0;
   int         ring_dist = 0;
   int         entry_tol = 0;
   int         exit_tol = 0;
   int         orbit_hold_ms = 0;
   int         align_enter = 0;
   int         align_exit = 0;
   int         align_hold_ms = 0;

   bts_pkg::rsp_type pending_status[$];
   int               mismatches = 0;
   int               quiet_cycles = 0;
   bit               req_burst = 1'b0;
   bit               rsp_burst = 1'b0;

   reg_set_type directed_sets [3] = '{
      '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF},
      '{16'd2000, 16'd100, 16'd300, 16'd50, 16'd500, 16'd1000, 16'd40, 16'h5A5A},
      '{16'd4095, 16'h1000, 16'hF001, 16'hFFFF, 16'h7FFF, 16'd0, 16'hFFFF, 16'hFFFF}
   };

   tick_row_type directed_ticks [22] = '{
      '{0, 1'b0, 0, 0, 0, 0, 1'b1, bts_pkg::CODE_SEARCH, 0, 0},
      '{0, 1'b1, 0, 0, 0, 100, 1'b1, bts_pkg::CODE_SEARCH, 0, 0},
      '{0, 1'b1, 4095, 0, 0, 65535, 1'b1, bts_pkg::CODE_ORBIT, 0, 0},
      '{0, 1'b1, 0, 0, 0, 65535, 1'b1, bts_pkg::CODE_ORBIT, 65535, 0},
      '{0, 1'b1, 0, 0, 0, 65535, 1'b1, bts_pkg::CODE_ORBIT, 65535, 0},
      '{0, 1'b1, 4095, 18000, -18000, 1, 1'b1, bts_pkg::CODE_CAPTURED, 65535, 0},
      '{0, 1'b1, 4095, -32768, 32767, 0, 1'b1, bts_pkg::CODE_ORBIT, 0, 0},
      '{0, 1'b1, 4095, 32767, -32768, 0, 1'b1, bts_pkg::CODE_ORBIT, 0, 0},
      '{0, 1'b1, 4095, 100, 100, 5, 1'b1, bts_pkg::CODE_CAPTURED, 5, 0},
      '{0, 1'b1, 4095, -18000, 18000, 7, 1'b1, bts_pkg::CODE_CAPTURED, 5, 0},
      '{0, 1'b0, 4095, -1, 1, 65535, 1'b1, bts_pkg::CODE_SEARCH, 0, 0},
      '{1, 1'b1, 1950, 0, 0, 30, 1'b0, bts_pkg::CODE_SEARCH, 0, 0},
      '{1, 1'b1, 1950, 0, 0, 20, 1'b0, bts_pkg::CODE_SEARCH, 0, 0},
      '{1, 1'b1, 2100, 0, 400, 25, 1'b0, bts_pkg::CODE_SEARCH, 0, 0},
      '{1, 1'b1, 2100, 0, 400, 20, 1'b0, bts_pkg::CODE_SEARCH, 0, 0},
      '{1, 1'b1, 2100, 0, -900, 9, 1'b0, bts_pkg::CODE_SEARCH, 0, 0},
      '{1, 1'b1, 2100, 0, -1001, 9, 1'b0, bts_pkg::CODE_SEARCH, 0, 0},
      '{1, 1'b1, 1600, 0, 0, 10, 1'b0, bts_pkg::CODE_SEARCH, 0, 0},
      '{1, 1'b1, 1600, 0, 0, 10, 1'b0, bts_pkg::CODE_SEARCH, 0, 0},
      '{2, 1'b1, 0, 0, 0, 40000, 1'b0, bts_pkg::CODE_SEARCH, 0, 0},
      '{2, 1'b1, 4095, 12345, -12345, 65535, 1'b0, bts_pkg::CODE_SEARCH, 0, 0},
      '{2, 1'b0, 2048, 0, 0, 0, 1'b0, bts_pkg::CODE_SEARCH, 0, 0}
   };

   ball_tracking_stage_fsm_top DUT (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int sat_ms(int v);
      return (v > TIMER_MAX) ? TIMER_MAX : v;
   endfunction

   function automatic bts_pkg::rsp_type track_tick(bts_pkg::req_type r);
      int               dist_err;
      int               dir;
      int               tgt;
      int               herr;
      int               dt;
      bts_pkg::rsp_type o;
      if (!r.ball_found) begin
         track_stage = bts_pkg::CODE_SEARCH;
         align_acc = 0;
         orbit_acc = 0;
      end else begin
         dist_err = ring_dist - int'(r.signal_strength);
         dir = int'($signed(r.ball_direction));
         tgt = int'($signed(r.target_heading));
         dt = int'(r.elapsed_ms);
         herr = (tgt - dir) % int'(bts_pkg::FULL_TURN);
         if (herr < 0) herr += int'(bts_pkg::FULL_TURN);
         if (herr > int'(bts_pkg::HALF_TURN)) herr = int'(bts_pkg::FULL_TURN) - herr;
         case (track_stage)
            bts_pkg::CODE_SEARCH, bts_pkg::CODE_APPROACH: begin
               if (dist_err < entry_tol) begin
                  orbit_acc = sat_ms(orbit_acc + dt);
                  if (orbit_acc >= orbit_hold_ms) begin
                     track_stage = bts_pkg::CODE_ORBIT;
                     orbit_acc = 0;
                  end
               end else begin
                  orbit_acc = 0;
               end
            end
            bts_pkg::CODE_ORBIT: begin
               if (dist_err > exit_tol) begin
                  track_stage = bts_pkg::CODE_APPROACH;
                  align_acc = 0;
               end else if (herr > align_enter) begin
                  align_acc = 0;
               end else begin
                  align_acc = sat_ms(align_acc + dt);
                  if (align_acc >= align_hold_ms && int'(r.signal_strength) > ring_dist)
                     track_stage = bts_pkg::CODE_CAPTURED;
               end
            end
            default: begin
               if (herr > align_exit) begin
                  track_stage = bts_pkg::CODE_ORBIT;
                  align_acc = 0;
               end
            end
         endcase
      end
      o.stage = track_stage;
      o.aligned_ms = align_acc[bts_pkg::MS_BITS-1:0];
      o.orbit_ms = orbit_acc[bts_pkg::MS_BITS-1:0];
      return o;
   endfunction

   task automatic set_register(logic [bts_pkg::IDX_BITS-1:0] idx,
                               logic [bts_pkg::CSR_BITS-1:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      case (idx)
         bts_pkg::CSR_ORBIT_DISTANCE:  ring_dist = int'(v[bts_pkg::DIST_BITS-1:0]);
         bts_pkg::CSR_ORBIT_ENTRY_TOL: entry_tol = int'($signed(v[bts_pkg::TOL_BITS-1:0]));
         bts_pkg::CSR_ORBIT_EXIT_TOL:  exit_tol = int'($signed(v[bts_pkg::TOL_BITS-1:0]));
         bts_pkg::CSR_ORBIT_DEBOUNCE:  orbit_hold_ms = int'(v[bts_pkg::MS_BITS-1:0]);
         bts_pkg::CSR_ENTER_ALIGN_TOL: align_enter = int'(v[bts_pkg::HERR_BITS-1:0]);
         bts_pkg::CSR_EXIT_ALIGN_TOL:  align_exit = int'(v[bts_pkg::HERR_BITS-1:0]);
         bts_pkg::CSR_ALIGN_DEBOUNCE:  align_hold_ms = int'(v[bts_pkg::MS_BITS-1:0]);
         default: ;
      endcase
   endtask

   // hold requests until every response is back
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_status.size() != 0) @(posedge clock);
   endtask

   task automatic apply_setting(reg_set_type s);
      drain();
      for (int i = 0; i < NUM_INDEXES; i++) set_register(i[bts_pkg::IDX_BITS-1:0], s[i]);
      csr_we <= 1'b0;
   endtask

   task automatic send_request(bts_pkg::req_type r, bit typed, bts_pkg::rsp_type typed_rsp);
      int               gap;
      bts_pkg::rsp_type predicted;
      gap = req_burst ? 0 : int'($urandom_range(0, 18));
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      predicted = track_tick(r);
      pending_status.push_back(typed ? typed_rsp : predicted);
      req_tvalid <= 1'b1;
      req_tuser <= r.ball_found;
      req_tdata <= {4'b0, r.elapsed_ms, r.target_heading, r.ball_direction, r.signal_strength};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic reg_set_type draw_setting(int phase);
      reg_set_type s;
      for (int i = 0; i < NUM_INDEXES; i++) s[i] = 16'($urandom_range(0, 65535));
      if (phase == 0) begin
         s[bts_pkg::CSR_ORBIT_DISTANCE] = 16'd4095;
         s[bts_pkg::CSR_ORBIT_ENTRY_TOL] = 16'd4095;
         s[bts_pkg::CSR_ORBIT_EXIT_TOL] = 16'd4095;
         s[bts_pkg::CSR_ORBIT_DEBOUNCE] = 16'hFFFF;
         s[bts_pkg::CSR_ENTER_ALIGN_TOL] = 16'd18000;
         s[bts_pkg::CSR_EXIT_ALIGN_TOL] = 16'd18000;
         s[bts_pkg::CSR_ALIGN_DEBOUNCE] = 16'hFFFF;
      end else if (phase == 1) begin
         s[bts_pkg::CSR_ORBIT_DISTANCE] = 16'd0;
         s[bts_pkg::CSR_ORBIT_ENTRY_TOL] = 16'hF001;
         s[bts_pkg::CSR_ORBIT_EXIT_TOL] = 16'hF001;
         s[bts_pkg::CSR_ORBIT_DEBOUNCE] = 16'd0;
         s[bts_pkg::CSR_ENTER_ALIGN_TOL] = 16'd0;
         s[bts_pkg::CSR_EXIT_ALIGN_TOL] = 16'd0;
         s[bts_pkg::CSR_ALIGN_DEBOUNCE] = 16'd0;
      end else begin
         // mostly usable values, now and then a raw word
         if ($urandom_range(0, 7) != 0)
            s[bts_pkg::CSR_ORBIT_DISTANCE] = 16'($urandom_range(0, 4095));
         if ($urandom_range(0, 7) != 0)
            s[bts_pkg::CSR_ORBIT_ENTRY_TOL] = 16'(int'($urandom_range(0, 600)) - 200);
         if ($urandom_range(0, 7) != 0)
            s[bts_pkg::CSR_ORBIT_EXIT_TOL] = 16'(int'($urandom_range(0, 800)) - 200);
         if ($urandom_range(0, 7) != 0)
            s[bts_pkg::CSR_ORBIT_DEBOUNCE] = 16'($urandom_range(0, 300));
         if ($urandom_range(0, 7) != 0)
            s[bts_pkg::CSR_ENTER_ALIGN_TOL] = 16'($urandom_range(0, 6000));
         if ($urandom_range(0, 7) != 0)
            s[bts_pkg::CSR_EXIT_ALIGN_TOL] = 16'($urandom_range(0, 8000));
         if ($urandom_range(0, 7) != 0)
            s[bts_pkg::CSR_ALIGN_DEBOUNCE] = 16'($urandom_range(0, 300));
      end
      return s;
   endfunction

   function automatic bts_pkg::req_type draw_tick();
      bts_pkg::req_type r;
      int               sig;
      int               dir;
      int               delta;
      int               hold;
      if ($urandom_range(0, 9) == 0) begin
         r.ball_found = 1'($urandom_range(0, 1));
         r.signal_strength = 12'($urandom);
         r.ball_direction = 16'($urandom);
         r.target_heading = 16'($urandom);
         r.elapsed_ms = 16'($urandom);
         return r;
      end
      // near the distance and heading thresholds, with short ticks
      r.ball_found = ($urandom_range(0, 29) != 0);
      case ($urandom_range(0, 3))
         0: sig = ring_dist - entry_tol + int'($urandom_range(0, 60)) - 30;
         1: sig = ring_dist - exit_tol + int'($urandom_range(0, 60)) - 30;
         default: sig = ring_dist + int'($urandom_range(1, 100));
      endcase
      if (sig < 0) sig = 0;
      if (sig > 4095) sig = 4095;
      r.signal_strength = 12'(sig);
      if ($urandom_range(0, 7) == 0) dir = int'($urandom_range(0, 65535)) - 32768;
      else dir = int'($urandom_range(0, 36000)) - 18000;
      case ($urandom_range(0, 2))
         0: delta = align_enter + int'($urandom_range(0, 200)) - 100;
         1: delta = align_exit + int'($urandom_range(0, 200)) - 100;
         default: delta = int'($urandom_range(0, 100));
      endcase
      if (delta < 0) delta = 0;
      if ($urandom_range(0, 1) == 0) delta = -delta;
      if ($urandom_range(0, 7) == 0) delta = (delta < 0) ? delta + int'(bts_pkg::FULL_TURN)
                                                          : delta - int'(bts_pkg::FULL_TURN);
      r.ball_direction = 16'(dir);
      r.target_heading = 16'(dir + delta);
      hold = (orbit_hold_ms > align_hold_ms) ? orbit_hold_ms : align_hold_ms;
      case ($urandom_range(0, 19))
         0: r.elapsed_ms = 16'hFFFF;
         1: r.elapsed_ms = 16'($urandom);
         default: r.elapsed_ms = 16'($urandom_range(0, hold / 6 + 3));
      endcase
      return r;
   endfunction

   initial begin
      int stall;
      forever begin
         stall = rsp_burst ? 0 : int'($urandom_range(0, 18));
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   always @(posedge clock) begin
      bts_pkg::rsp_type got;
      bts_pkg::rsp_type want;
      if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got.stage = rsp_tdata[1:0];
         got.aligned_ms = rsp_tdata[2 +: bts_pkg::MS_BITS];
         got.orbit_ms = rsp_tdata[2 + bts_pkg::MS_BITS +: bts_pkg::MS_BITS];
         if (pending_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: stage %0d aligned %0d orbit %0d",
                        got.stage, got.aligned_ms, got.orbit_ms);
         end else begin
            want = pending_status.pop_front();
            if (got.stage !== want.stage || got.aligned_ms !== want.aligned_ms ||
                got.orbit_ms !== want.orbit_ms) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected stage %0d aligned %0d orbit %0d, got %0d %0d %0d",
                           want.stage, want.aligned_ms, want.orbit_ms,
                           got.stage, got.aligned_ms, got.orbit_ms);
            end
         end
      end
   end

   initial begin
      while (quiet_cycles < IDLE_LIMIT) @(posedge clock);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      bts_pkg::req_type r;
      bts_pkg::rsp_type typed_rsp;
      int               cur_setting;
      int               sent;
      int               phase;
      int               phase_len;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      cur_setting = -1;
      foreach (directed_ticks[i]) begin
         if (directed_ticks[i].setting != cur_setting) begin
            cur_setting = directed_ticks[i].setting;
            apply_setting(directed_sets[cur_setting]);
         end
         r.ball_found = directed_ticks[i].found;
         r.signal_strength = 12'(directed_ticks[i].sig);
         r.ball_direction = 16'(directed_ticks[i].dir);
         r.target_heading = 16'(directed_ticks[i].tgt);
         r.elapsed_ms = 16'(directed_ticks[i].ms);
         typed_rsp.stage = directed_ticks[i].stage;
         typed_rsp.aligned_ms = 16'(directed_ticks[i].aligned);
         typed_rsp.orbit_ms = 16'(directed_ticks[i].orbit);
         send_request(r, directed_ticks[i].typed, typed_rsp);
      end

      sent = 0;
      phase = 0;
      while (sent < RANDOM_TICKS) begin
         apply_setting(draw_setting(phase));
         req_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
         phase_len = int'($urandom_range(60, 180));
         repeat (phase_len) begin
            if (sent < RANDOM_TICKS) begin
               if ($urandom_range(0, 99) == 0) drain();
               send_request(draw_tick(), 1'b0, typed_rsp);
               sent++;
            end
         end
         phase++;
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_status.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/bts_pkg.sv
hw/rtl/bts_heading_err.sv
hw/rtl/bts_stage_core.sv
hw/rtl/ball_tracking_stage_fsm_top.sv
test/tb_top.sv
